// ===== sv/wpsc_pkg.sv =====
// Shared constants and types for the windowed PID steering controller.
`default_nettype none

package wpsc_pkg;

   localparam int HEADING_W   = 16;
   localparam int DIST_W      = 16;
   localparam int GAIN_W      = 16;
   localparam int LIMIT_W     = 15;
   localparam int CMD_OUT_W   = 16;
   localparam int WSUM_W      = 20;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam int WINDOW    = 16;
   localparam int LOOP_RATE = 10;

   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = HEADING_W + $clog2(WINDOW);
   localparam int DIFF_W = HEADING_W + 1;

   localparam int P_W = GAIN_W + 1 + HEADING_W;
   localparam int D_W = GAIN_W + 1 + DIFF_W;
   localparam int I_W = GAIN_W + 1 + SUM_W;

   localparam int NUM_A = D_W + $clog2(LOOP_RATE * LOOP_RATE + 1) + 1;
   localparam int NUM_B = I_W + 1;
   localparam int NUM_W = ((NUM_A > NUM_B) ? NUM_A : NUM_B) + 2;

   localparam longint DEN    = longint'(LOOP_RATE) * 256;
   localparam longint SAT_Q  = 65536;
   localparam int     CMD_W  = $clog2(SAT_Q) + 2;
   localparam longint UMAX   = 2 * SAT_Q * DEN;
   localparam longint OFFSET = DEN / 2 + SAT_Q * DEN;

   localparam int     U_W     = $clog2(UMAX + 1);
   localparam int     RECIP_S = U_W + $clog2(DEN);
   localparam int     C_W     = U_W + 2;
   localparam int     PROD_W  = U_W + C_W;
   localparam longint RECIP   = ((longint'(1) << RECIP_S) + DEN - 1) / DEN;

   localparam int SUM_EXT_W = (SUM_W > WSUM_W) ? SUM_W : WSUM_W;
   localparam int WSUM_MAX  = 2 ** (WSUM_W - 1) - 1;
   localparam int WSUM_MIN  = -(2 ** (WSUM_W - 1));

   localparam int DB_NARROW = 14;
   localparam int DB_WIDE   = 81;
   localparam int NEAR_DIST = 896;

   localparam int GAIN_P_RESET       = 256;
   localparam int GAIN_I_RESET       = 0;
   localparam int GAIN_D_RESET       = 0;
   localparam int STEP_LIMIT_RESET   = 32767;
   localparam int OUTPUT_LIMIT_RESET = 32767;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GAIN_P       = 3'd0,
      CSR_GAIN_I       = 3'd1,
      CSR_GAIN_D       = 3'd2,
      CSR_STEP_LIMIT   = 3'd3,
      CSR_OUTPUT_LIMIT = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic out;
   } stage_en_type;

endpackage

`default_nettype wire

// ===== sv/wpsc_cell.sv =====
// One cell of the error window shift chain.
`default_nettype none

module wpsc_cell (
   input  logic                                  clock,
   input  logic                                  shift_en,
   input  logic signed [wpsc_pkg::HEADING_W-1:0] data_in,
   output logic signed [wpsc_pkg::HEADING_W-1:0] data_out
);

   logic signed [wpsc_pkg::HEADING_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ===== sv/wpsc_window.sv =====
// Error window: cell chain, fill count, running sum and first pipeline stage.
`default_nettype none

module wpsc_window (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wpsc_pkg::stage_en_type                stage_en,
   input  logic signed [wpsc_pkg::HEADING_W-1:0] heading_error,
   output logic signed [wpsc_pkg::HEADING_W-1:0] error_s1,
   output logic signed [wpsc_pkg::DIFF_W-1:0]    diff_s1,
   output logic signed [wpsc_pkg::SUM_W-1:0]     sum_s1
);

   logic signed [wpsc_pkg::HEADING_W-1:0] link [wpsc_pkg::WINDOW+1];

   logic        [wpsc_pkg::FILL_W-1:0]    fill_ff;
   logic        [wpsc_pkg::FILL_W-1:0]    fill_in;
   logic signed [wpsc_pkg::SUM_W-1:0]     sum_ff;
   logic signed [wpsc_pkg::SUM_W-1:0]     sum_in;
   logic signed [wpsc_pkg::SUM_W-1:0]     oldest;
   logic signed [wpsc_pkg::HEADING_W-1:0] prev_err_ff;
   logic signed [wpsc_pkg::DIFF_W-1:0]    diff_ff;
   logic signed [wpsc_pkg::DIFF_W-1:0]    diff_in;
   logic                                  full;

   assign link[0] = heading_error;

   for (genvar i = 0; i < wpsc_pkg::WINDOW; i++) begin : g_cell
      wpsc_cell u_cell (
         .clock    (clock),
         .shift_en (stage_en.s1),
         .data_in  (link[i]),
         .data_out (link[i+1])
      );
   end

   assign full = (fill_ff == wpsc_pkg::FILL_W'(wpsc_pkg::WINDOW));

   always_comb begin
      fill_in = full ? fill_ff : fill_ff + 1'b1;
      oldest  = full ? wpsc_pkg::SUM_W'(link[wpsc_pkg::WINDOW]) : '0;
      sum_in  = sum_ff + wpsc_pkg::SUM_W'(heading_error) - oldest;
      diff_in = wpsc_pkg::DIFF_W'(heading_error) - wpsc_pkg::DIFF_W'(prev_err_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         sum_ff      <= '0;
         prev_err_ff <= '0;
      end else if (stage_en.s1) begin
         fill_ff     <= fill_in;
         sum_ff      <= sum_in;
         prev_err_ff <= heading_error;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         diff_ff <= diff_in;
      end
   end

   // The state registers already hold the newest transaction's values.
   assign error_s1 = prev_err_ff;
   assign sum_s1   = sum_ff;
   assign diff_s1  = diff_ff;

endmodule

`default_nettype wire

// ===== sv/wpsc_gain.sv =====
// Gain products, term sum with rounding, and reciprocal division stages.
`default_nettype none

module wpsc_gain (
   input  logic                                  clock,
   input  wpsc_pkg::stage_en_type                stage_en,
   input  logic        [wpsc_pkg::GAIN_W-1:0]    gain_p,
   input  logic        [wpsc_pkg::GAIN_W-1:0]    gain_i,
   input  logic        [wpsc_pkg::GAIN_W-1:0]    gain_d,
   input  logic signed [wpsc_pkg::HEADING_W-1:0] error_s1,
   input  logic signed [wpsc_pkg::DIFF_W-1:0]    diff_s1,
   input  logic signed [wpsc_pkg::SUM_W-1:0]     sum_s1,
   output logic signed [wpsc_pkg::CMD_W-1:0]     cmd_raw
);

   logic signed [wpsc_pkg::P_W-1:0]    p_ff;
   logic signed [wpsc_pkg::P_W-1:0]    p_in;
   logic signed [wpsc_pkg::D_W-1:0]    d_ff;
   logic signed [wpsc_pkg::D_W-1:0]    d_in;
   logic signed [wpsc_pkg::I_W-1:0]    i_ff;
   logic signed [wpsc_pkg::I_W-1:0]    i_in;
   logic signed [wpsc_pkg::NUM_W-1:0]  x_in;
   logic        [wpsc_pkg::U_W-1:0]    u_ff;
   logic        [wpsc_pkg::U_W-1:0]    u_in;
   logic        [wpsc_pkg::PROD_W-1:0] prod_ff;
   logic        [wpsc_pkg::PROD_W-1:0] prod_in;

   always_comb begin
      p_in = $signed({1'b0, gain_p}) * error_s1;
      d_in = $signed({1'b0, gain_d}) * diff_s1;
      i_in = $signed({1'b0, gain_i}) * sum_s1;
   end

   // The sum is offset so that the rounded quotient is always non-negative.
   always_comb begin
      x_in = wpsc_pkg::NUM_W'(p_ff) * wpsc_pkg::LOOP_RATE
           + wpsc_pkg::NUM_W'(d_ff) * (wpsc_pkg::LOOP_RATE * wpsc_pkg::LOOP_RATE)
           + wpsc_pkg::NUM_W'(i_ff)
           + wpsc_pkg::NUM_W'(wpsc_pkg::OFFSET);
      if (x_in < 0) begin
         u_in = '0;
      end else if (x_in > wpsc_pkg::UMAX) begin
         u_in = wpsc_pkg::U_W'(wpsc_pkg::UMAX);
      end else begin
         u_in = wpsc_pkg::U_W'(x_in);
      end
   end

   assign prod_in = wpsc_pkg::PROD_W'(u_ff) * wpsc_pkg::PROD_W'(wpsc_pkg::RECIP);

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         p_ff <= p_in;
         d_ff <= d_in;
         i_ff <= i_in;
      end
      if (stage_en.s3) begin
         u_ff <= u_in;
      end
      if (stage_en.s4) begin
         prod_ff <= prod_in;
      end
   end

   assign cmd_raw = $signed(prod_ff[wpsc_pkg::RECIP_S +: wpsc_pkg::CMD_W])
                  - wpsc_pkg::CMD_W'(wpsc_pkg::SAT_Q);

endmodule

`default_nettype wire

// ===== sv/windowed_pid_steering_control_top.sv =====
// Top level of the windowed PID steering controller.
// The controller is a five-stage pipeline that accepts one transaction per cycle when
// the result side is not stalled, and registers each result in the window, gain,
// sum, product and output stages in turn before presenting it. The last sixteen heading
// errors shift through a chain of sixteen cells while a running sum is kept beside it.
// The stages are: window update, gain
// products, term sum with rounding, reciprocal multiply for the division by
// 256 * LOOP_RATE, then slope limit, magnitude clamp and deadband into the output
// register. The previous command feeds back only inside that last stage, which is
// what allows a new transaction in every cycle that the result side is not stalled.
// Each stage holds its transaction when the next one is full and cannot move on, so
// inputs keep flowing into empty stages while a result waits. Configuration writes
// are taken at any time; they must only be issued while the pipeline is empty.
`default_nettype none

module windowed_pid_steering_control_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [wpsc_pkg::HEADING_W-1:0]   req_heading_error,
   input  logic        [wpsc_pkg::DIST_W-1:0]      req_aim_distance,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [wpsc_pkg::CMD_OUT_W-1:0]   rsp_angular_command,
   output logic signed [wpsc_pkg::WSUM_W-1:0]      rsp_window_error_sum,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [wpsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [wpsc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   wpsc_pkg::stage_en_type stage_en;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, rsp_valid_ff;
   logic s1_ready, s2_ready, s3_ready, s4_ready, out_ready;

   logic [wpsc_pkg::GAIN_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [wpsc_pkg::LIMIT_W-1:0] step_limit_ff, output_limit_ff;

   logic [wpsc_pkg::DIST_W-1:0] dist_s1_ff, dist_s2_ff, dist_s3_ff, dist_s4_ff;
   logic signed [wpsc_pkg::WSUM_W-1:0] wsum_in, wsum_s2_ff, wsum_s3_ff, wsum_s4_ff;
   logic signed [wpsc_pkg::SUM_EXT_W-1:0] sum_ext;

   logic signed [wpsc_pkg::HEADING_W-1:0] error_s1;
   logic signed [wpsc_pkg::DIFF_W-1:0]    diff_s1;
   logic signed [wpsc_pkg::SUM_W-1:0]     sum_s1;
   logic signed [wpsc_pkg::CMD_W-1:0]     cmd_raw;

   logic signed [wpsc_pkg::CMD_W-1:0] step_s, lim_s, neg_lim, hi, lo, slope_cmd, clamp_cmd, mag;
   logic                              dead;
   logic signed [wpsc_pkg::CMD_OUT_W-1:0] cmd_in, cmd_ff, prev_cmd_ff;
   logic signed [wpsc_pkg::WSUM_W-1:0]    wsum_out_ff;

   // Stage handshake: a stage takes new data when it is empty or moving on.
   always_comb begin
      out_ready = !rsp_valid_ff || rsp_ready;
      s4_ready  = !s4_valid_ff || out_ready;
      s3_ready  = !s3_valid_ff || s4_ready;
      s2_ready  = !s2_valid_ff || s3_ready;
      s1_ready  = !s1_valid_ff || s2_ready;
      stage_en.s1  = req_valid && s1_ready;
      stage_en.s2  = s1_valid_ff && s2_ready;
      stage_en.s3  = s2_valid_ff && s3_ready;
      stage_en.s4  = s3_valid_ff && s4_ready;
      stage_en.out = s4_valid_ff && out_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= wpsc_pkg::GAIN_W'(wpsc_pkg::GAIN_P_RESET);
         gain_i_ff       <= wpsc_pkg::GAIN_W'(wpsc_pkg::GAIN_I_RESET);
         gain_d_ff       <= wpsc_pkg::GAIN_W'(wpsc_pkg::GAIN_D_RESET);
         step_limit_ff   <= wpsc_pkg::LIMIT_W'(wpsc_pkg::STEP_LIMIT_RESET);
         output_limit_ff <= wpsc_pkg::LIMIT_W'(wpsc_pkg::OUTPUT_LIMIT_RESET);
      end else if (csr_valid) begin
         case (wpsc_pkg::csr_index_type'(csr_index))
            wpsc_pkg::CSR_GAIN_P: begin
               gain_p_ff <= csr_wdata;
            end
            wpsc_pkg::CSR_GAIN_I: begin
               gain_i_ff <= csr_wdata;
            end
            wpsc_pkg::CSR_GAIN_D: begin
               gain_d_ff <= csr_wdata;
            end
            wpsc_pkg::CSR_STEP_LIMIT: begin
               step_limit_ff <= csr_wdata[wpsc_pkg::LIMIT_W-1:0];
            end
            wpsc_pkg::CSR_OUTPUT_LIMIT: begin
               output_limit_ff <= csr_wdata[wpsc_pkg::LIMIT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   wpsc_window u_window (
      .clock         (clock),
      .reset         (reset),
      .stage_en      (stage_en),
      .heading_error (req_heading_error),
      .error_s1      (error_s1),
      .diff_s1       (diff_s1),
      .sum_s1        (sum_s1)
   );

   wpsc_gain u_gain (
      .clock    (clock),
      .stage_en (stage_en),
      .gain_p   (gain_p_ff),
      .gain_i   (gain_i_ff),
      .gain_d   (gain_d_ff),
      .error_s1 (error_s1),
      .diff_s1  (diff_s1),
      .sum_s1   (sum_s1),
      .cmd_raw  (cmd_raw)
   );

   always_comb begin
      sum_ext = wpsc_pkg::SUM_EXT_W'(sum_s1);
      if (sum_ext > wpsc_pkg::WSUM_MAX) begin
         wsum_in = wpsc_pkg::WSUM_W'(wpsc_pkg::WSUM_MAX);
      end else if (sum_ext < wpsc_pkg::WSUM_MIN) begin
         wsum_in = wpsc_pkg::WSUM_W'(wpsc_pkg::WSUM_MIN);
      end else begin
         wsum_in = wpsc_pkg::WSUM_W'(sum_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.s1) begin
         dist_s1_ff <= req_aim_distance;
      end
      if (stage_en.s2) begin
         dist_s2_ff <= dist_s1_ff;
         wsum_s2_ff <= wsum_in;
      end
      if (stage_en.s3) begin
         dist_s3_ff <= dist_s2_ff;
         wsum_s3_ff <= wsum_s2_ff;
      end
      if (stage_en.s4) begin
         dist_s4_ff <= dist_s3_ff;
         wsum_s4_ff <= wsum_s3_ff;
      end
   end

   always_comb begin
      step_s  = $signed({{(wpsc_pkg::CMD_W - wpsc_pkg::LIMIT_W){1'b0}}, step_limit_ff});
      lim_s   = $signed({{(wpsc_pkg::CMD_W - wpsc_pkg::LIMIT_W){1'b0}}, output_limit_ff});
      neg_lim = -lim_s;
      hi      = wpsc_pkg::CMD_W'(prev_cmd_ff) + step_s;
      lo      = wpsc_pkg::CMD_W'(prev_cmd_ff) - step_s;
      if (cmd_raw > hi) begin
         slope_cmd = hi;
      end else if (cmd_raw < lo) begin
         slope_cmd = lo;
      end else begin
         slope_cmd = cmd_raw;
      end
      if (slope_cmd > lim_s) begin
         clamp_cmd = lim_s;
      end else if (slope_cmd < neg_lim) begin
         clamp_cmd = neg_lim;
      end else begin
         clamp_cmd = slope_cmd;
      end
      mag  = (clamp_cmd < 0) ? -clamp_cmd : clamp_cmd;
      dead = (mag <= wpsc_pkg::DB_NARROW)
          || ((mag <= wpsc_pkg::DB_WIDE) && (dist_s4_ff < wpsc_pkg::NEAR_DIST));
      cmd_in = dead ? '0 : clamp_cmd[wpsc_pkg::CMD_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_cmd_ff <= '0;
      end else if (stage_en.out) begin
         prev_cmd_ff <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.out) begin
         cmd_ff      <= cmd_in;
         wsum_out_ff <= wsum_s4_ff;
      end
   end

   assign req_ready            = s1_ready;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_angular_command  = cmd_ff;
   assign rsp_window_error_sum = wsum_out_ff;

endmodule

`default_nettype wire

// ===== sv/wpsc_checker.sv =====
// Port-level checker for the windowed PID steering controller, bound to the top level.
`default_nettype none

module wpsc_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [wpsc_pkg::CMD_OUT_W-1:0]   rsp_angular_command,
   input logic signed [wpsc_pkg::WSUM_W-1:0]      rsp_window_error_sum
);

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_result_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angular_command)
                                  && $stable(rsp_window_error_sum))
      else $error("stalled result transaction changed");

   a_cmd_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_angular_command != 16'h8000)
      else $error("command outside the clamp range");

   a_deadband : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angular_command == 0)
                 || (rsp_angular_command > wpsc_pkg::DB_NARROW)
                 || (rsp_angular_command < -wpsc_pkg::DB_NARROW))
      else $error("small command escaped the deadband");

endmodule

bind windowed_pid_steering_control_top wpsc_checker u_wpsc_checker (.*);

`default_nettype wire
